// ===== design/dtq_pkg.sv =====
// Shared types and constants for the delta timer queue.
`default_nettype none

package dtq_pkg;

   localparam int CAPACITY    = 16;
   localparam int DELAY_BITS  = 16;
   localparam int HANDLE_BITS = 8;
   localparam int CELL_BITS   = $clog2(CAPACITY);
   localparam int COUNT_BITS  = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      OP_ADD       = 2'd0,
      OP_TICK      = 2'd1,
      OP_TAKE_DUE  = 2'd2,
      OP_TAKE_TAIL = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_TICK   = 2'd1,
      CMD_INSERT = 2'd2,
      CMD_POP    = 2'd3
   } cmd_op_type;

   // Broadcast to every cell in a cycle.
   typedef struct packed {
      cmd_op_type             op;
      logic [DELAY_BITS-1:0]  delay;
      logic [HANDLE_BITS-1:0] handle;
   } cmd_type;

   // One slot of the queue: absolute ticks until due, and its handle.
   typedef struct packed {
      logic [DELAY_BITS-1:0]  due;
      logic [HANDLE_BITS-1:0] handle;
   } entry_type;

   // Where a cell sits relative to the fill level.
   typedef struct packed {
      logic active;
      logic at_tail;
   } slot_type;

endpackage

`default_nettype wire

// ===== design/dtq_cell.sv =====
// One queue cell: holds an entry and shifts with its neighbors.
`default_nettype none

module dtq_cell (
   input  wire                       clock,
   input  wire dtq_pkg::cmd_type     cmd,
   input  wire dtq_pkg::slot_type    slot,
   input  wire dtq_pkg::entry_type   left_entry,
   input  wire                       left_gt,
   input  wire dtq_pkg::entry_type   right_entry,
   output dtq_pkg::entry_type        entry,
   output logic                      gt
);

   dtq_pkg::entry_type entry_ff;
   dtq_pkg::entry_type entry_in;

   // The new request goes before every active entry due strictly later.
   assign gt    = slot.active && (entry_ff.due > cmd.delay);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         dtq_pkg::CMD_TICK: begin
            entry_in.due = entry_ff.due - dtq_pkg::DELAY_BITS'(1);
         end
         dtq_pkg::CMD_INSERT: begin
            if (left_gt) begin
               entry_in = left_entry;
            end else if (gt || slot.at_tail) begin
               entry_in.due    = cmd.delay;
               entry_in.handle = cmd.handle;
            end
         end
         dtq_pkg::CMD_POP: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// ===== design/delta_timer_queue.sv =====
// Top level of the delta timer queue: request decode, cell row, result register.
//
//   channel | ports                                         | direction
//   req     | req_valid req_ready req_operation req_handle  | in
//           | req_delay                                     |
//   rsp     | rsp_valid rsp_ready rsp_status rsp_out_handle | out
//           | rsp_pending                                   |
//
// Each request is decoded and applied to the whole cell row; its result
// appears in the result register on the next cycle, so one request per
// cycle while the result side keeps taking. Reset empties the queue at once.
// A stalled result holds the row; a new request is taken in the cycle the
// waiting result leaves.
`default_nettype none

module delta_timer_queue (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  [1:0]                          req_operation,
   input  wire  [dtq_pkg::HANDLE_BITS-1:0]     req_handle,
   input  wire  [dtq_pkg::DELAY_BITS-1:0]      req_delay,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [dtq_pkg::HANDLE_BITS-1:0]     rsp_out_handle,
   output logic [dtq_pkg::COUNT_BITS-1:0]      rsp_pending
);

   localparam logic [dtq_pkg::COUNT_BITS-1:0] FULL_COUNT =
      dtq_pkg::COUNT_BITS'(dtq_pkg::CAPACITY);

   logic [dtq_pkg::COUNT_BITS-1:0]  count_ff, count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   dtq_pkg::status_type             status_ff, status_in;
   logic [dtq_pkg::HANDLE_BITS-1:0] got_ff, got_in;
   logic [dtq_pkg::COUNT_BITS-1:0]  pending_ff;

   dtq_pkg::cmd_type   cmd;
   dtq_pkg::entry_type entry_w       [dtq_pkg::CAPACITY];
   dtq_pkg::entry_type left_entry_w  [dtq_pkg::CAPACITY];
   dtq_pkg::entry_type right_entry_w [dtq_pkg::CAPACITY];
   dtq_pkg::slot_type  slot_w        [dtq_pkg::CAPACITY];
   logic [dtq_pkg::CAPACITY-1:0] gt_w;
   logic [dtq_pkg::CAPACITY-1:0] left_gt_w;

   logic                          accept;
   logic [dtq_pkg::CELL_BITS-1:0] tail_idx;
   logic                          empty;

   assign req_ready      = !rsp_valid_ff || rsp_ready;
   assign accept         = req_valid && req_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_out_handle = got_ff;
   assign rsp_pending    = pending_ff;

   assign empty    = (count_ff == '0);
   assign tail_idx = dtq_pkg::CELL_BITS'(count_ff - dtq_pkg::COUNT_BITS'(1));

   // Neighbor wiring and fill-level flags for each cell.
   always_comb begin
      for (int i = 0; i < dtq_pkg::CAPACITY; i++) begin
         slot_w[i].active  = (dtq_pkg::COUNT_BITS'(i) < count_ff);
         slot_w[i].at_tail = (dtq_pkg::COUNT_BITS'(i) == count_ff);
         if (i == 0) begin
            left_entry_w[i] = '0;
            left_gt_w[i]    = 1'b0;
         end else begin
            left_entry_w[i] = entry_w[i-1];
            left_gt_w[i]    = gt_w[i-1];
         end
         if (i == dtq_pkg::CAPACITY - 1) begin
            right_entry_w[i] = entry_w[i];
         end else begin
            right_entry_w[i] = entry_w[i+1];
         end
      end
   end

   for (genvar g = 0; g < dtq_pkg::CAPACITY; g++) begin : g_cell
      dtq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .slot        (slot_w[g]),
         .left_entry  (left_entry_w[g]),
         .left_gt     (left_gt_w[g]),
         .right_entry (right_entry_w[g]),
         .entry       (entry_w[g]),
         .gt          (gt_w[g])
      );
   end

   // Decode the request; cells hold unless a request is taken this cycle.
   always_comb begin
      cmd.op     = dtq_pkg::CMD_HOLD;
      cmd.delay  = req_delay;
      cmd.handle = req_handle;
      count_in   = count_ff;
      status_in  = dtq_pkg::STATUS_EMPTY;
      got_in     = '0;
      unique case (dtq_pkg::op_type'(req_operation))
         dtq_pkg::OP_ADD: begin
            if (count_ff == FULL_COUNT) begin
               status_in = dtq_pkg::STATUS_FULL;
            end else begin
               cmd.op    = dtq_pkg::CMD_INSERT;
               count_in  = count_ff + dtq_pkg::COUNT_BITS'(1);
               status_in = dtq_pkg::STATUS_OK;
            end
         end
         dtq_pkg::OP_TICK: begin
            // Drop the tick when the queue is empty or the head is already due.
            if (!empty && entry_w[0].due != '0) begin
               cmd.op    = dtq_pkg::CMD_TICK;
               status_in = dtq_pkg::STATUS_OK;
            end
         end
         dtq_pkg::OP_TAKE_DUE: begin
            if (!empty && entry_w[0].due == '0) begin
               cmd.op    = dtq_pkg::CMD_POP;
               count_in  = count_ff - dtq_pkg::COUNT_BITS'(1);
               status_in = dtq_pkg::STATUS_OK;
               got_in    = entry_w[0].handle;
            end
         end
         dtq_pkg::OP_TAKE_TAIL: begin
            if (!empty) begin
               count_in  = count_ff - dtq_pkg::COUNT_BITS'(1);
               status_in = dtq_pkg::STATUS_OK;
               got_in    = entry_w[tail_idx].handle;
            end
         end
         default: begin
            status_in = dtq_pkg::STATUS_EMPTY;
         end
      endcase
      if (!accept) begin
         cmd.op   = dtq_pkg::CMD_HOLD;
         count_in = count_ff;
      end
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff  <= status_in;
         got_ff     <= got_in;
         pending_ff <= count_in;
      end
   end

endmodule

`default_nettype wire
